### design/hfn_pkg.sv
// ----------------------------------------------------------------------------
// hfn_pkg
// shared types and constants of the height field normal pipeline
// ----------------------------------------------------------------------------
package hfn_pkg;

  localparam int unsigned DimW    = 13;
  localparam int unsigned PosW    = 12;
  localparam int unsigned HeightW = 16;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned OutW    = 16;
  localparam int unsigned MagW    = 30;
  localparam int unsigned SumW    = 62;
  localparam int unsigned RootW   = 64;
  localparam int unsigned LenW    = 31;
  localparam int unsigned QuotW   = 15;
  localparam int unsigned RemW    = 46;
  localparam int unsigned SqrtSteps = 32;

  localparam logic [1:0] CfgGridWidth  = 2'd0;
  localparam logic [1:0] CfgGridHeight = 2'd1;
  localparam logic [1:0] CfgScale      = 2'd2;

  localparam logic [QuotW-1:0] OneQ14 = 15'd16384;

  // per-component magnitudes and signs carried down the pipeline
  typedef struct packed {
    logic [2:0]      neg;
    logic [MagW-1:0] mag0;
    logic [MagW-1:0] mag1;
    logic [MagW-1:0] mag2;
  } carry_t;

  typedef struct packed {
    logic [RemW-1:0]  rem0;
    logic [RemW-1:0]  rem1;
    logic [RemW-1:0]  rem2;
    logic [QuotW-1:0] q0;
    logic [QuotW-1:0] q1;
    logic [QuotW-1:0] q2;
    logic [2:0]       neg;
    logic [LenW-1:0]  len;
  } div_t;

endpackage

### design/heightfield_normal.sv
// ----------------------------------------------------------------------------
// heightfield_normal
// unit surface normal of a height grid sample from central differences
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle (busy_o stays low) and its normal
// appears on done_o once it has passed the input stages, the square root
// (one result bit per stage over 32 stages) and the divider (one quotient
// bit per stage over 15 stages), both fully pipelined, and the output
// register. There is no back pressure: every result is shown for exactly one cycle.
module heightfield_normal #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [hfn_pkg::PosW-1:0]      col_i,
  input  logic [hfn_pkg::PosW-1:0]      row_i,
  input  logic signed [hfn_pkg::HeightW-1:0] h_center_i,
  input  logic signed [hfn_pkg::HeightW-1:0] h_left_i,
  input  logic signed [hfn_pkg::HeightW-1:0] h_right_i,
  input  logic signed [hfn_pkg::HeightW-1:0] h_below_i,
  input  logic signed [hfn_pkg::HeightW-1:0] h_above_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  output logic                          done_o,
  output logic signed [hfn_pkg::OutW-1:0] normal_x_o,
  output logic signed [hfn_pkg::OutW-1:0] normal_up_o,
  output logic signed [hfn_pkg::OutW-1:0] normal_y_o
);
  import hfn_pkg::*;

  localparam logic [16:0] MaxDimC = 17'(MAX_DIM);

  logic [DimW-1:0]   grid_width_q, grid_height_q;
  logic [ScaleW-1:0] height_scale_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= 13'd256;
      grid_height_q  <= 13'd256;
      height_scale_q <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGridWidth:  grid_width_q   <= cfg_data_i[DimW-1:0];
        CfgGridHeight: grid_height_q  <= cfg_data_i[DimW-1:0];
        CfgScale:      height_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: edge handling and raw differences
  logic [16:0] wsat, hsat;
  logic        col_first, col_last, row_first, row_last;
  logic signed [16:0] dx_d, dy_d;
  logic signed [16:0] dx_q, dy_q;
  logic        cx_d, cy_d, cx_q, cy_q, v1_q;
  logic signed [16:0] hc, hl, hr, hb, ha;

  always_comb begin
    wsat = ({4'b0, grid_width_q} > MaxDimC) ? MaxDimC : {4'b0, grid_width_q};
    hsat = ({4'b0, grid_height_q} > MaxDimC) ? MaxDimC : {4'b0, grid_height_q};
    hc = 17'(h_center_i);
    hl = 17'(h_left_i);
    hr = 17'(h_right_i);
    hb = 17'(h_below_i);
    ha = 17'(h_above_i);
    col_first = (col_i == '0);
    row_first = (row_i == '0);
    col_last  = !col_first && (wsat != '0) && ({5'b0, col_i} == wsat - 17'd1);
    row_last  = !row_first && (hsat != '0) && ({5'b0, row_i} == hsat - 17'd1);
    cx_d = !col_first && !col_last;
    cy_d = !row_first && !row_last;
    if (col_first)     dx_d = hr - hc;
    else if (col_last) dx_d = hc - hl;
    else               dx_d = hr - hl;
    if (row_first)     dy_d = ha - hc;
    else if (row_last) dy_d = hc - hb;
    else               dy_d = ha - hb;
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
  end

  // stage 2: scale
  logic signed [33:0] sx_q, sy_q;
  logic        cx2_q, cy2_q, v2_q;
  always_ff @(posedge clk_i) begin
    sx_q  <= dx_q * $signed({1'b0, height_scale_q});
    sy_q  <= dy_q * $signed({1'b0, height_scale_q});
    cx2_q <= cx_q;
    cy2_q <= cy_q;
  end

  // stage 3: sign and magnitude of each component
  logic [33:0] ax, ay;
  logic [34:0] m0_q, m2_q;
  logic [10:0] m1_q;
  logic [2:0]  neg3_q;
  logic        v3_q;
  always_comb begin
    ax = sx_q[33] ? 34'(-sx_q) : 34'(sx_q);
    ay = sy_q[33] ? 34'(-sy_q) : 34'(sy_q);
  end
  always_ff @(posedge clk_i) begin
    m0_q   <= cy2_q ? {ax, 1'b0} : {1'b0, ax};
    m2_q   <= cx2_q ? {ay, 1'b0} : {1'b0, ay};
    m1_q   <= 11'd256 << ({1'b0, cx2_q} + {1'b0, cy2_q});
    neg3_q <= {!sy_q[33] && (sy_q != '0), 1'b0, !sx_q[33] && (sx_q != '0)};
  end

  // stage 4: common range reduction below 2^30
  logic [4:0] top;
  logic [2:0] shamt;
  carry_t     c4_q;
  logic       v4_q;
  always_comb begin
    top = m0_q[34:30] | m2_q[34:30];
    if (top[4])      shamt = 3'd5;
    else if (top[3]) shamt = 3'd4;
    else if (top[2]) shamt = 3'd3;
    else if (top[1]) shamt = 3'd2;
    else if (top[0]) shamt = 3'd1;
    else             shamt = 3'd0;
  end
  always_ff @(posedge clk_i) begin
    c4_q.mag0 <= MagW'(m0_q >> shamt);
    c4_q.mag1 <= MagW'({24'b0, m1_q} >> shamt);
    c4_q.mag2 <= MagW'(m2_q >> shamt);
    c4_q.neg  <= neg3_q;
  end

  // stage 5: squares
  logic [59:0] p0_q, p1_q, p2_q;
  carry_t      c5_q;
  logic        v5_q;
  always_ff @(posedge clk_i) begin
    p0_q <= c4_q.mag0 * c4_q.mag0;
    p1_q <= c4_q.mag1 * c4_q.mag1;
    p2_q <= c4_q.mag2 * c4_q.mag2;
    c5_q <= c4_q;
  end

  // stage 6: sum of squares
  logic [RootW-1:0] rv_q [0:SqrtSteps];
  logic [RootW-1:0] rr_q [0:SqrtSteps];
  carry_t           rc_q [0:SqrtSteps];
  logic             rvld_q [0:SqrtSteps];
  always_ff @(posedge clk_i) begin
    rv_q[0] <= RootW'({2'b0, p0_q} + {2'b0, p1_q} + {2'b0, p2_q});
    rr_q[0] <= '0;
    rc_q[0] <= c5_q;
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam logic [RootW-1:0] BitC = RootW'(64'd1 << (62 - 2 * j));
    logic [RootW-1:0] trial;
    assign trial = rr_q[j] + BitC;
    always_ff @(posedge clk_i) begin
      if (rv_q[j] >= trial) begin
        rv_q[j+1] <= rv_q[j] - trial;
        rr_q[j+1] <= (rr_q[j] >> 1) + BitC;
      end else begin
        rv_q[j+1] <= rv_q[j];
        rr_q[j+1] <= rr_q[j] >> 1;
      end
      rc_q[j+1] <= rc_q[j];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rvld_q[j+1] <= 1'b0;
      end else begin
        rvld_q[j+1] <= rvld_q[j];
      end
    end
  end

  // numerators with rounding
  logic [LenW-1:0] len;
  div_t            dv_q [0:QuotW];
  logic            dvld_q [0:QuotW];
  always_comb begin
    len = rr_q[SqrtSteps][LenW-1:0];
    if (len == '0) len = LenW'(1);
  end
  always_ff @(posedge clk_i) begin
    dv_q[0].rem0 <= {2'b0, rc_q[SqrtSteps].mag0, 14'b0} + RemW'(len >> 1);
    dv_q[0].rem1 <= {2'b0, rc_q[SqrtSteps].mag1, 14'b0} + RemW'(len >> 1);
    dv_q[0].rem2 <= {2'b0, rc_q[SqrtSteps].mag2, 14'b0} + RemW'(len >> 1);
    dv_q[0].q0   <= '0;
    dv_q[0].q1   <= '0;
    dv_q[0].q2   <= '0;
    dv_q[0].neg  <= rc_q[SqrtSteps].neg;
    dv_q[0].len  <= len;
  end

  // restoring division, one quotient bit per stage
  for (genvar m = 0; m < QuotW; m++) begin : g_div
    localparam int unsigned K = QuotW - 1 - m;
    logic [RemW-1:0] dsr;
    logic            t0, t1, t2;
    assign dsr = RemW'(dv_q[m].len) << K;
    assign t0  = dv_q[m].rem0 >= dsr;
    assign t1  = dv_q[m].rem1 >= dsr;
    assign t2  = dv_q[m].rem2 >= dsr;
    always_ff @(posedge clk_i) begin
      dv_q[m+1].rem0  <= t0 ? dv_q[m].rem0 - dsr : dv_q[m].rem0;
      dv_q[m+1].rem1  <= t1 ? dv_q[m].rem1 - dsr : dv_q[m].rem1;
      dv_q[m+1].rem2  <= t2 ? dv_q[m].rem2 - dsr : dv_q[m].rem2;
      dv_q[m+1].q0    <= dv_q[m].q0 | (QuotW'(t0) << K);
      dv_q[m+1].q1    <= dv_q[m].q1 | (QuotW'(t1) << K);
      dv_q[m+1].q2    <= dv_q[m].q2 | (QuotW'(t2) << K);
      dv_q[m+1].neg   <= dv_q[m].neg;
      dv_q[m+1].len   <= dv_q[m].len;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[m+1] <= 1'b0;
      end else begin
        dvld_q[m+1] <= dvld_q[m];
      end
    end
  end

  // output register with sign
  logic [QuotW-1:0] f0, f1, f2;
  always_comb begin
    f0 = (dv_q[QuotW].q0 > OneQ14) ? OneQ14 : dv_q[QuotW].q0;
    f1 = (dv_q[QuotW].q1 > OneQ14) ? OneQ14 : dv_q[QuotW].q1;
    f2 = (dv_q[QuotW].q2 > OneQ14) ? OneQ14 : dv_q[QuotW].q2;
  end
  always_ff @(posedge clk_i) begin
    normal_x_o  <= dv_q[QuotW].neg[0] ? -$signed({1'b0, f0}) : $signed({1'b0, f0});
    normal_up_o <= dv_q[QuotW].neg[1] ? -$signed({1'b0, f1}) : $signed({1'b0, f1});
    normal_y_o  <= dv_q[QuotW].neg[2] ? -$signed({1'b0, f2}) : $signed({1'b0, f2});
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      rvld_q[0] <= 1'b0;
      dvld_q[0] <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      v1_q      <= start_i && !busy_o;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      rvld_q[0] <= v5_q;
      dvld_q[0] <= rvld_q[SqrtSteps];
      done_o    <= dvld_q[QuotW];
    end
  end

endmodule

### test/heightfield_normal_tb.sv
// ----------------------------------------------------------------------------
// heightfield_normal_tb
// self-checking bench for the height field normal pipeline
// ----------------------------------------------------------------------------
// Drives a table of directed samples, then random samples under a series of
// grid and scale settings (including degenerate and oversized ones). Each
// result is compared field by field, oldest expectation first, with the table
// entry of a checked row or else an in-bench fixed point normal calculator.
module heightfield_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hfn_pkg::*;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int         WatchLimit = 2000;
  localparam int         DrainWait  = 80;

  typedef struct packed {
    logic [PosW-1:0]           col;
    logic [PosW-1:0]           row;
    logic signed [HeightW-1:0] hc;
    logic signed [HeightW-1:0] hl;
    logic signed [HeightW-1:0] hr;
    logic signed [HeightW-1:0] hb;
    logic signed [HeightW-1:0] ha;
  } sample_t;

  typedef struct packed {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] up;
    logic signed [OutW-1:0] y;
  } normal_t;

  typedef struct packed {
    sample_t s;
    logic    chk;
    normal_t n;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] sc;
    logic        poke_unused;
  } setting_t;

  localparam int DirRows = 12;
  localparam dir_row_t DirTab [DirRows] = '{
    '{'{12'd5, 12'd5, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      1'b1, '{16'sd0, 16'sd16384, 16'sd0}},
    '{'{12'd5, 12'd5, 16'sh0000, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000},
      1'b1, '{-16'sd16384, 16'sd1, 16'sd0}},
    '{'{12'd5, 12'd5, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh7fff},
      1'b1, '{16'sd0, 16'sd1, -16'sd16384}},
    '{'{12'd5, 12'd5, 16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000},
      1'b1, '{16'sd16384, 16'sd1, 16'sd0}},
    '{'{12'd0, 12'd0, 16'sh8000, 16'sh1234, 16'sh7fff, 16'sh4321, 16'sh0100},
      1'b0, '0},
    '{'{12'd255, 12'd255, 16'sh0040, 16'shff00, 16'sh5555, 16'shaaaa, 16'sh0001},
      1'b0, '0},
    '{'{12'd4095, 12'd4095, 16'sh0003, 16'sh0010, 16'shfff0, 16'sh0020, 16'sh0007},
      1'b0, '0},
    '{'{12'd256, 12'd300, 16'sh0100, 16'sh0101, 16'sh00ff, 16'sh0102, 16'sh00fe},
      1'b0, '0},
    '{'{12'd0, 12'd255, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
      1'b0, '0},
    '{'{12'd255, 12'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      1'b0, '0},
    '{'{12'd254, 12'd1, 16'sh0000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000},
      1'b0, '0},
    '{'{12'd3071, 12'd1365, 16'sh0a5a, 16'shf5a5, 16'sh0f0f, 16'shf0f0, 16'sh3c3c},
      1'b0, '0}
  };

  localparam int Phases = 10;
  localparam setting_t Settings [Phases] = '{
    '{16'd256,   16'd256,   16'd256,   1'b0},
    '{16'd2,     16'd2,     16'd0,     1'b0},
    '{16'd4096,  16'd4096,  16'd65535, 1'b0},
    '{16'd1,     16'd1,     16'd256,   1'b0},
    '{16'd0,     16'd0,     16'd300,   1'b1},
    '{16'hffff,  16'd4097,  16'd1,     1'b0},
    '{16'd3,     16'd700,   16'd128,   1'b0},
    '{16'd17,    16'd4095,  16'd40000, 1'b0},
    '{16'd640,   16'd9,     16'd777,   1'b0},
    '{16'd100,   16'd100,   16'd512,   1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [PosW-1:0] col_i = '0;
  logic [PosW-1:0] row_i = '0;
  logic signed [HeightW-1:0] h_center_i = '0;
  logic signed [HeightW-1:0] h_left_i = '0;
  logic signed [HeightW-1:0] h_right_i = '0;
  logic signed [HeightW-1:0] h_below_i = '0;
  logic signed [HeightW-1:0] h_above_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic done_o;
  logic signed [OutW-1:0] normal_x_o;
  logic signed [OutW-1:0] normal_up_o;
  logic signed [OutW-1:0] normal_y_o;

  heightfield_normal dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [DimW-1:0]   grid_w = 13'd256;
  logic [DimW-1:0]   grid_h = 13'd256;
  logic [ScaleW-1:0] scale  = 16'd256;

  normal_t pending_normals[$];
  int      mismatches = 0;
  int      idle_cycles = 0;

  function automatic bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint axis_slope(int unsigned pos, int unsigned dim, longint lo,
                                        longint mid, longint hi, output longint step);
    int unsigned d;
    longint sc;
    d = (dim > 4096) ? 4096 : dim;
    sc = longint'(scale);
    if (pos == 0) begin
      step = 1;
      return (hi - mid) * sc;
    end
    if (d != 0 && pos == d - 1) begin
      step = 1;
      return (mid - lo) * sc;
    end
    step = 2;
    return (hi - lo) * sc;
  endfunction

  function automatic normal_t surface_normal(sample_t s);
    longint sx, sy, dx, dy;
    longint comp [3];
    bit [63:0] mag [3];
    bit [63:0] sum, len, q;
    int sh;
    logic signed [OutW-1:0] o [3];
    dx = axis_slope(s.col, grid_w, s.hl, s.hc, s.hr, sx);
    dy = axis_slope(s.row, grid_h, s.hb, s.hc, s.ha, sy);
    comp[0] = -dx * sy;
    comp[1] = 256 * sx * sy;
    comp[2] = -dy * sx;
    for (int i = 0; i < 3; i++) mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
    sh = 0;
    while ((mag[0] >> sh) >= (64'd1 << 30) || (mag[1] >> sh) >= (64'd1 << 30) ||
           (mag[2] >> sh) >= (64'd1 << 30))
      sh++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    len = root_floor(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      o[i] = (comp[i] < 0) ? -q[15:0] : q[15:0];
    end
    return '{o[0], o[1], o[2]};
  endfunction

  function automatic logic [PosW-1:0] pick_pos(logic [DimW-1:0] dim);
    int unsigned d;
    d = (dim > 4096) ? 4096 : dim;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PosW'(d - 1);
      2: return PosW'(d - 2);
      3: return PosW'($urandom_range(0, 4095));
      default: return PosW'($urandom % ((d == 0) ? 1 : d));
    endcase
  endfunction

  function automatic logic signed [HeightW-1:0] pick_height(logic signed [HeightW-1:0] base);
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return HeightW'($urandom);
      default: return base + HeightW'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.col = pick_pos(grid_w);
    s.row = pick_pos(grid_h);
    s.hc = HeightW'($urandom);
    s.hl = pick_height(s.hc);
    s.hr = pick_height(s.hc);
    s.hb = pick_height(s.hc);
    s.ha = pick_height(s.hc);
    return s;
  endfunction

  // holds start high until the transfer; caller lowers it when pausing
  task automatic send_sample(sample_t s, logic chk, normal_t typed);
    start_i    <= 1'b1;
    col_i      <= s.col;
    row_i      <= s.row;
    h_center_i <= s.hc;
    h_left_i   <= s.hl;
    h_right_i  <= s.hr;
    h_below_i  <= s.hb;
    h_above_i  <= s.ha;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_normals.push_back(chk ? typed : surface_normal(s));
  endtask

  task automatic pause_sender(bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgGridWidth:  grid_w = data[DimW-1:0];
      CfgGridHeight: grid_h = data[DimW-1:0];
      CfgScale:      scale  = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_normals.size() != 0) @(posedge clk_i);
  endtask

  // result check and watchdog
  always @(posedge clk_i) begin
    normal_t want;
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d up=%0d y=%0d", normal_x_o, normal_up_o,
                   normal_y_o);
      end else begin
        want = pending_normals.pop_front();
        if (want.x !== normal_x_o || want.up !== normal_up_o || want.y !== normal_y_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                     want.x, want.up, want.y, normal_x_o, normal_up_o, normal_y_o);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_sample(DirTab[i].s, DirTab[i].chk, DirTab[i].n);
      pause_sender(1'b1);
    end

    for (int p = 0; p < Phases; p++) begin
      start_i <= 1'b0;
      wait_drained();
      if (p != 0) begin
        cfg_write(CfgGridWidth, Settings[p].w);
        cfg_write(CfgGridHeight, Settings[p].h);
        cfg_write(CfgScale, Settings[p].sc);
        if (Settings[p].poke_unused) cfg_write(CfgUnused, 16'hffff);
        cfg_valid_i <= 1'b0;
      end
      for (int n = 0; n < 105; n++) begin
        send_sample(random_sample(), 1'b0, '0);
        if (p == 2 && n == 50) begin
          start_i <= 1'b0;
          wait_drained();
        end else begin
          pause_sender(p != Phases - 1);
        end
      end
    end

    start_i <= 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
